// ===== hw/rtl/x86enc_pkg.sv =====
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared constants and types of the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

  localparam int unsigned MaxBytes = 16;

  typedef logic [3:0] cnt_t;          // byte count minus one, 0..15

  localparam logic [7:0] OpRexBase = 8'h40;
  localparam logic [7:0] OpSize16  = 8'h66;

  // Condition codes of the setcc forms, in form order.
  function automatic logic [7:0] setcc_op(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h92;
      4'd1:    r = 8'h97;
      4'd2:    r = 8'h96;
      4'd3:    r = 8'h93;
      4'd4:    r = 8'h9c;
      4'd5:    r = 8'h9f;
      4'd6:    r = 8'h9e;
      4'd7:    r = 8'h9d;
      4'd8:    r = 8'h94;
      default: r = 8'h95;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/x86_64_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder
// Encodes one instruction request into its machine-code bytes, one per beat.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Beats per item   Payload
// in_      slave      1                action, size, regs, offset, immediate
// out_     master     1 to 10          one code byte, last, error
//
// A request is accepted into the encode stage, where the whole byte string
// (up to 10 bytes) is built by combinational logic and registered into a
// byte buffer. The buffer then sends one byte per cycle while out_tready is
// high; the output port is the limit. The next request is taken in the cycle
// in which the last byte of the current one leaves, so bytes stream without
// gaps. Reset empties the buffer; a stalled output holds its byte.
module x86_64_instruction_encoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: action[5:0], size_code[1:0], reg_a[3:0], reg_b[3:0],
  // reg_index[2:0], offset[31:0], immediate[63:0], zero fill to 120 bits
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: code_byte[7:0]
  output logic [7:0]   out_tdata,
  output logic         out_tlast,
  // tuser: error
  output logic         out_tuser
);

  logic [5:0]  act;
  logic [1:0]  sz;
  logic [3:0]  ra, rb;
  logic [2:0]  rx;
  logic [31:0] off;
  logic [63:0] imm;

  assign act = in_tdata[5:0];
  assign sz  = in_tdata[7:6];
  assign ra  = in_tdata[11:8];
  assign rb  = in_tdata[15:12];
  assign rx  = in_tdata[18:16];
  assign off = in_tdata[50:19];
  assign imm = in_tdata[114:51];

  // Byte buffer and read pointer.
  logic [7:0]                  buf_r [x86enc_pkg::MaxBytes];
  logic [7:0]                  buf_nxt [x86enc_pkg::MaxBytes];
  x86enc_pkg::cnt_t            len_r, len_nxt, ptr_r;
  logic                        busy_r, err_r, err_nxt;
  logic [4:0]                  n;

  wire fire_out = out_tvalid && out_tready;
  wire at_end   = (ptr_r == len_r);
  assign in_tready  = !busy_r || (fire_out && at_end);
  assign out_tvalid = busy_r;
  assign out_tdata  = buf_r[ptr_r];
  assign out_tlast  = at_end;
  assign out_tuser  = err_r;

  function automatic logic fits8(input logic [31:0] v);
    return (v[31:7] == 25'h0) || (v[31:7] == 25'h1ffffff);
  endfunction

  // Encoder: append bytes to buf_nxt at position n.
  always_comb begin
    logic [7:0]  b0;
    logic        s8;
    logic [1:0]  md;
    logic [2:0]  rr;
    logic [7:0]  op;
    logic        wide;
    for (int i = 0; i < x86enc_pkg::MaxBytes; i++) buf_nxt[i] = 8'h00;
    n = 5'd0;
    err_nxt = 1'b0;
    s8 = fits8(off);
    md = 2'd0;
    rr = rb[2:0];
    op = 8'h00;
    b0 = 8'h00;
    wide = 1'b0;
    unique case (act)
      6'd0: begin buf_nxt[0] = 8'h50 + {5'd0, ra[2:0]}; n = 5'd1; end
      6'd1, 6'd12, 6'd14, 6'd15, 6'd19, 6'd21: begin
        unique case (act)
          6'd1:    op = 8'h89;
          6'd12:   op = 8'h03;
          6'd14:   op = 8'h2b;
          6'd15:   op = 8'h33;
          6'd19:   op = 8'h23;
          default: op = 8'h0b;
        endcase
        buf_nxt[0] = 8'h48; buf_nxt[1] = op;
        buf_nxt[2] = {2'b11, ra[2:0], rb[2:0]}; n = 5'd3;
      end
      6'd2: begin
        buf_nxt[0] = 8'hb8 + {5'd0, ra[2:0]};
        {buf_nxt[4], buf_nxt[3], buf_nxt[2], buf_nxt[1]} = imm[31:0]; n = 5'd5;
      end
      6'd3: begin buf_nxt[0] = 8'h58 + {5'd0, ra[2:0]}; n = 5'd1; end
      6'd4: begin buf_nxt[0] = 8'hC3; n = 5'd1; end
      6'd5, 6'd6: begin
        rr = (act == 6'd5) ? 3'd5 : 3'd0;
        buf_nxt[0] = 8'h48;
        buf_nxt[2] = {2'b11, rr, ra[2:0]};
        if (fits8(imm[31:0])) begin
          buf_nxt[1] = 8'h83; buf_nxt[3] = imm[7:0]; n = 5'd4;
        end else begin
          buf_nxt[1] = 8'h81;
          {buf_nxt[6], buf_nxt[5], buf_nxt[4], buf_nxt[3]} = imm[31:0]; n = 5'd7;
        end
      end
      6'd7, 6'd8: begin
        // Prefix and opcode.
        if (act == 6'd7) begin
          b0 = {4'h4, 1'b0, rb[3], 1'b0, ra[3]};
          unique case (sz)
            2'd0: begin buf_nxt[0] = b0; buf_nxt[1] = 8'h88; n = 5'd2; end
            2'd1: begin
              buf_nxt[0] = x86enc_pkg::OpSize16;
              if (rb[3] | ra[3]) begin
                buf_nxt[1] = b0; buf_nxt[2] = 8'h89; n = 5'd3;
              end else begin
                buf_nxt[1] = 8'h89; n = 5'd2;
              end
            end
            2'd2: begin
              if (rb[3] | ra[3]) begin
                buf_nxt[0] = b0; buf_nxt[1] = 8'h89; n = 5'd2;
              end else begin
                buf_nxt[0] = 8'h89; n = 5'd1;
              end
            end
            default: begin
              buf_nxt[0] = b0 | 8'h08; buf_nxt[1] = 8'h89; n = 5'd2;
            end
          endcase
        end else begin
          unique case (sz)
            2'd0:    begin buf_nxt[0] = x86enc_pkg::OpRexBase; buf_nxt[1] = 8'h8a; end
            2'd1:    begin buf_nxt[0] = x86enc_pkg::OpSize16;  buf_nxt[1] = 8'h8b; end
            2'd2:    buf_nxt[0] = 8'h8b;
            default: begin buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h8b; end
          endcase
          n = (sz == 2'd2) ? 5'd1 : 5'd2;
        end
        buf_nxt[n[3:0]] = {s8 ? 2'b01 : 2'b10, rb[2:0], ra[2:0]};
        n = n + 5'd1;
        if (ra[2:0] == 3'd4) begin
          buf_nxt[n[3:0]] = s8 ? 8'h24 : 8'hA4; n = n + 5'd1;
        end
        if (s8) begin
          buf_nxt[n[3:0]] = off[7:0]; n = n + 5'd1;
        end else begin
          for (int i = 0; i < 4; i++) buf_nxt[n[3:0] + 4'(i)] = off[8*i +: 8];
          n = n + 5'd4;
        end
      end
      6'd9, 6'd10: begin
        op = (act == 6'd9) ? 8'h8b : 8'h89;
        unique case (sz)
          2'd0:    begin buf_nxt[0] = x86enc_pkg::OpRexBase; buf_nxt[1] = op - 8'd1; end
          2'd1:    begin buf_nxt[0] = x86enc_pkg::OpSize16;  buf_nxt[1] = op; end
          2'd2:    buf_nxt[0] = op;
          default: begin buf_nxt[0] = 8'h48; buf_nxt[1] = op; end
        endcase
        n = (sz == 2'd2) ? 5'd1 : 5'd2;
        if (ra[2:0] == 3'd5) begin
          buf_nxt[n[3:0]]        = {2'b01, rb[2:0], 3'd4};
          buf_nxt[n[3:0] + 4'd1] = {2'b00, rx, 3'd5};
          buf_nxt[n[3:0] + 4'd2] = 8'h00;
          n = n + 5'd3;
        end else begin
          buf_nxt[n[3:0]]        = {2'b00, rb[2:0], 3'd4};
          buf_nxt[n[3:0] + 4'd1] = {2'b00, rx, ra[2:0]};
          n = n + 5'd2;
        end
      end
      6'd11: begin
        buf_nxt[0] = 8'h48; buf_nxt[1] = 8'hb8 + {4'd0, ra};
        for (int i = 0; i < 8; i++) buf_nxt[2 + i] = imm[8*i +: 8];
        n = 5'd10;
      end
      6'd13: begin
        buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h0f; buf_nxt[2] = 8'haf;
        buf_nxt[3] = {2'b11, ra[2:0], rb[2:0]}; n = 5'd4;
      end
      6'd16, 6'd17, 6'd22, 6'd23: begin
        unique case (act)
          6'd16:   begin op = 8'hf7; rr = 3'd6; end
          6'd17:   begin op = 8'hf7; rr = 3'd7; end
          6'd22:   begin op = 8'hd3; rr = 3'd4; end
          default: begin op = 8'hd3; rr = 3'd5; end
        endcase
        buf_nxt[0] = 8'h48; buf_nxt[1] = op;
        buf_nxt[2] = {2'b11, rr, ra[2:0]}; n = 5'd3;
      end
      6'd18: begin buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h99; n = 5'd2; end
      6'd20: begin
        if (ra == 4'd0) begin
          buf_nxt[0] = 8'h24; buf_nxt[1] = imm[7:0]; n = 5'd2;
        end else begin
          err_nxt = 1'b1; n = 5'd1;
        end
      end
      6'd24: begin
        buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h83;
        buf_nxt[2] = {2'b11, 3'd6, ra[2:0]}; buf_nxt[3] = imm[7:0]; n = 5'd4;
      end
      6'd25: begin
        unique case (sz)
          2'd0:    begin buf_nxt[0] = x86enc_pkg::OpRexBase; buf_nxt[1] = 8'h38; end
          2'd1:    begin buf_nxt[0] = x86enc_pkg::OpSize16;  buf_nxt[1] = 8'h39; end
          2'd2:    buf_nxt[0] = 8'h39;
          default: begin buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h39; end
        endcase
        n = (sz == 2'd2) ? 5'd1 : 5'd2;
        buf_nxt[n[3:0]] = {2'b11, rb[2:0], ra[2:0]}; n = n + 5'd1;
      end
      6'd26: begin
        buf_nxt[0] = 8'h40; buf_nxt[1] = 8'h80;
        buf_nxt[2] = {2'b11, 3'd7, ra[2:0]}; buf_nxt[3] = imm[7:0]; n = 5'd4;
      end
      6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36: begin
        buf_nxt[0] = 8'h40; buf_nxt[1] = 8'h0f;
        buf_nxt[2] = x86enc_pkg::setcc_op(4'(act - 6'd27));
        buf_nxt[3] = {2'b11, 3'd0, ra[2:0]}; n = 5'd4;
      end
      6'd37, 6'd38: begin
        buf_nxt[0] = 8'h0f; buf_nxt[1] = (act == 6'd37) ? 8'h84 : 8'h85;
        {buf_nxt[5], buf_nxt[4], buf_nxt[3], buf_nxt[2]} = off; n = 5'd6;
      end
      6'd39, 6'd41: begin
        buf_nxt[0] = (act == 6'd39) ? 8'he9 : 8'he8;
        {buf_nxt[4], buf_nxt[3], buf_nxt[2], buf_nxt[1]} = off; n = 5'd5;
      end
      6'd40: begin
        buf_nxt[0] = 8'hf6; buf_nxt[1] = {2'b11, 3'd0, ra[2:0]};
        buf_nxt[2] = imm[7:0]; n = 5'd3;
      end
      6'd42, 6'd43: begin
        buf_nxt[0] = 8'h48; buf_nxt[1] = (act == 6'd42) ? 8'h8b : 8'h8d;
        buf_nxt[2] = {2'b00, ra[2:0], 3'd5};
        {buf_nxt[6], buf_nxt[5], buf_nxt[4], buf_nxt[3]} = off; n = 5'd7;
      end
      6'd44: begin
        buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h8d;
        if (s8) begin
          buf_nxt[2] = {2'b01, ra[2:0], 3'd4}; buf_nxt[3] = 8'h24;
          buf_nxt[4] = off[7:0]; n = 5'd5;
        end else begin
          buf_nxt[2] = {2'b10, ra[2:0], 3'd4}; buf_nxt[3] = 8'hA4;
          {buf_nxt[7], buf_nxt[6], buf_nxt[5], buf_nxt[4]} = off; n = 5'd8;
        end
      end
      6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50: begin
        wide = 1'b1;
        if (act == 6'd49) begin
          buf_nxt[0] = 8'h8b; n = 5'd1;
        end else if (act == 6'd50) begin
          buf_nxt[0] = {4'h4, 1'b1, rb[3], 1'b0, ra[3]};
          buf_nxt[1] = 8'h8b; n = 5'd2;
        end else begin
          unique case (act)
            6'd45:   op = 8'hbe;
            6'd46:   op = 8'hbf;
            6'd47:   op = 8'hb6;
            default: op = 8'hb7;
          endcase
          buf_nxt[0] = 8'h48; buf_nxt[1] = 8'h0f; buf_nxt[2] = op; n = 5'd3;
        end
        if (off == 32'd0 && ra[2:0] != 3'd5) md = 2'd0;
        else if (s8)                         md = 2'd1;
        else                                 md = 2'd2;
        buf_nxt[n[3:0]] = {md, rb[2:0], ra[2:0]}; n = n + 5'd1;
        if (ra[2:0] == 3'd4) begin
          buf_nxt[n[3:0]] = 8'h24; n = n + 5'd1;
        end
        if (md == 2'd1) begin
          buf_nxt[n[3:0]] = off[7:0]; n = n + 5'd1;
        end else if (md == 2'd2) begin
          for (int i = 0; i < 4; i++) buf_nxt[n[3:0] + 4'(i)] = off[8*i +: 8];
          n = n + 5'd4;
        end
      end
      default: begin err_nxt = 1'b1; n = 5'd1; end
    endcase
    if (wide) err_nxt = 1'b0;
    len_nxt = 4'(n - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= '0;
    end else if (in_tvalid && in_tready) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
    end else if (fire_out) begin
      if (at_end) busy_r <= 1'b0;
      else        ptr_r  <= ptr_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_r <= buf_nxt;
      len_r <= len_nxt;
      err_r <= err_nxt;
    end
  end

endmodule
